@@ design/lfuc_pkg.sv @@
// Shared types and constants for the LFU cache table.
// Request and response words, engine control structs, state encoding.
// No dependencies.
package lfuc_pkg;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic ack;
  } eng_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPD_END,
    ST_DONE
  } eng_state_e;

endpackage

@@ design/lfuc_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module lfuc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/lfuc_engine.sv @@
// Lookup, victim search and table update for the LFU cache table.
// Sweeps the entry RAM once to scan and, for hits and inserts, once more to rewrite ranks and counts.
// Depends on lfuc_pkg and lfuc_ram.
module lfuc_engine import lfuc_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  eng_ctl_t         ctl_i,
  input  req_t             req_i,
  input  logic [CFG_W-1:0] cap_i,
  output eng_sts_t         sts_o,
  output rsp_t             rsp_o
);

  localparam int AW   = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int EW   = 64 + COUNT_BITS + AW;
  localparam int OW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (OW > CFG_W ? OW : CFG_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  eng_state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d, pidx_q, pidx_d;
  logic pv_q, pv_d;
  req_t req_q, req_d;
  rsp_t rsp_q, rsp_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [OW-1:0] occ_q, occ_d;
  logic found_q, found_d;
  logic [AW-1:0] fidx_q, fidx_d, frank_q, frank_d;
  logic [COUNT_BITS-1:0] fcnt_q, fcnt_d;
  logic [31:0] fdata_q, fdata_d;
  logic vic_any_q, vic_any_d;
  logic [AW-1:0] vidx_q, vidx_d, vrank_q, vrank_d;
  logic [COUNT_BITS-1:0] vcnt_q, vcnt_d;
  logic [31:0] vkey_q, vkey_d;
  logic free_any_q, free_any_d;
  logic [AW-1:0] fslot_q, fslot_d, slot_q, slot_d;
  logic ins_q, ins_d, evict_q, evict_d;

  logic we;
  logic [EW-1:0] wdata, rdata;
  logic [31:0] r_key, r_data;
  logic [COUNT_BITS-1:0] r_cnt;
  logic [AW-1:0] r_rank;
  logic [CMPW-1:0] cap_c, occ_c;
  logic ev_c;
  logic [AW-1:0] slot_c;

  assign r_key  = rdata[EW-1 -: 32];
  assign r_data = rdata[EW-33 -: 32];
  assign r_cnt  = rdata[AW +: COUNT_BITS];
  assign r_rank = rdata[AW-1:0];

  assign cap_c = (CMPW'(cap_i) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(cap_i);
  assign occ_c = CMPW'(occ_q);

  lfuc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pidx_q),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;  idx_d = idx_q;  pidx_d = pidx_q;  pv_d = pv_q;
    req_d = req_q;  rsp_d = rsp_q;  valid_d = valid_q;  occ_d = occ_q;
    found_d = found_q;  fidx_d = fidx_q;  frank_d = frank_q;
    fcnt_d = fcnt_q;  fdata_d = fdata_q;
    vic_any_d = vic_any_q;  vidx_d = vidx_q;  vrank_d = vrank_q;
    vcnt_d = vcnt_q;  vkey_d = vkey_q;
    free_any_d = free_any_q;  fslot_d = fslot_q;  slot_d = slot_q;
    ins_d = ins_q;  evict_d = evict_q;
    we = 1'b0;
    wdata = rdata;
    ev_c = 1'b0;
    slot_c = fslot_q;

    unique case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          req_d = req_i;
          idx_d = '0;
          found_d = 1'b0;
          vic_any_d = 1'b0;
          free_any_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN, ST_UPDATE: begin
        pv_d = 1'b1;
        pidx_d = idx_q;
        if (idx_q == LAST) begin
          state_d = (state_q == ST_SCAN) ? ST_SCAN_END : ST_UPD_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN_END: begin
        pv_d = 1'b0;
        state_d = ST_DECIDE;
      end
      ST_UPD_END: begin
        pv_d = 1'b0;
        state_d = ST_DONE;
      end
      ST_DECIDE: begin
        idx_d = '0;
        rsp_d.hit = found_q;
        rsp_d.read_value = '0;
        rsp_d.evicted = 1'b0;
        rsp_d.evicted_key = '0;
        ins_d = 1'b0;
        evict_d = 1'b0;
        state_d = ST_DONE;
        if (req_q.cmd == CMD_GET) begin
          if (found_q) begin
            rsp_d.read_value = fdata_q;
            fdata_d = fdata_q;
            state_d = ST_UPDATE;
          end else begin
            rsp_d.read_value = MISS_VALUE;
          end
        end else if (cap_c != '0) begin
          if (found_q) begin
            fdata_d = req_q.write_value;
            state_d = ST_UPDATE;
          end else begin
            ev_c = (occ_c >= cap_c) && vic_any_q;
            if (ev_c) begin
              slot_c = (free_any_q && fslot_q < vidx_q) ? fslot_q : vidx_q;
              valid_d[vidx_q] = 1'b0;
            end
            valid_d[slot_c] = 1'b1;
            occ_d = occ_q - OW'(ev_c) + 1'b1;
            rsp_d.evicted = ev_c;
            rsp_d.evicted_key = ev_c ? vkey_q : '0;
            ins_d = 1'b1;
            evict_d = ev_c;
            slot_d = slot_c;
            state_d = ST_UPDATE;
          end
        end
      end
      ST_DONE: begin
        if (ctl_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (pv_q && (state_q == ST_SCAN || state_q == ST_SCAN_END)) begin
      if (valid_q[pidx_q]) begin
        if (r_key == req_q.lookup_key) begin
          found_d = 1'b1;
          fidx_d = pidx_q;
          frank_d = r_rank;
          fcnt_d = r_cnt;
          fdata_d = r_data;
        end
        if (!vic_any_q || r_cnt < vcnt_q || (r_cnt == vcnt_q && r_rank > vrank_q)) begin
          vic_any_d = 1'b1;
          vidx_d = pidx_q;
          vcnt_d = r_cnt;
          vrank_d = r_rank;
          vkey_d = r_key;
        end
      end else if (!free_any_q) begin
        free_any_d = 1'b1;
        fslot_d = pidx_q;
      end
    end

    if (pv_q && (state_q == ST_UPDATE || state_q == ST_UPD_END)) begin
      if (ins_q) begin
        if (pidx_q == slot_q) begin
          we = 1'b1;
          wdata = {req_q.lookup_key, req_q.write_value, COUNT_BITS'(1), AW'(0)};
        end else if (valid_q[pidx_q]) begin
          we = 1'b1;
          wdata[AW-1:0] = r_rank - AW'(evict_q && r_rank > vrank_q) + 1'b1;
        end
      end else if (valid_q[pidx_q]) begin
        we = 1'b1;
        if (pidx_q == fidx_q) begin
          wdata = {r_key, fdata_q,
                   (fcnt_q == '1) ? fcnt_q : fcnt_q + 1'b1, AW'(0)};
        end else if (r_rank < frank_q) begin
          wdata[AW-1:0] = r_rank + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pv_q <= 1'b0;
      valid_q <= '0;
      occ_q <= '0;
    end else begin
      state_q <= state_d;
      pv_q <= pv_d;
      valid_q <= valid_d;
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;  pidx_q <= pidx_d;  req_q <= req_d;  rsp_q <= rsp_d;
    found_q <= found_d;  fidx_q <= fidx_d;  frank_q <= frank_d;
    fcnt_q <= fcnt_d;  fdata_q <= fdata_d;
    vic_any_q <= vic_any_d;  vidx_q <= vidx_d;  vrank_q <= vrank_d;
    vcnt_q <= vcnt_d;  vkey_q <= vkey_d;
    free_any_q <= free_any_d;  fslot_q <= fslot_d;  slot_q <= slot_d;
    ins_q <= ins_d;  evict_q <= evict_d;
  end

  assign sts_o.busy = (state_q != ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);
  assign rsp_o = rsp_q;

endmodule

@@ design/lfu_cache_table.sv @@
// Top level of the LFU cache table: config register, output register, engine.
// Depends on lfuc_pkg, lfuc_engine and lfuc_ram.
//
//   channel  direction  handshake                 word
//   in       sink       in_valid_i / in_stall_o   req_t
//   out      source     out_valid_o / out_stall_i rsp_t
//   cfg      sink       cfg_valid_i / cfg_ready_o capacity_in_use
//
// A request is one RAM sweep to match the key and find the victim, a decide
// state, and, for hits and inserts, a second sweep that rewrites ranks and
// counts through the single RAM read port.
// Misses on get and puts at capacity zero skip the second sweep.
// Reset empties the table at once. A result held by out_stall_i blocks the
// next request only once that request has finished.
module lfu_cache_table import lfuc_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [CFG_W-1:0] cap_q;
  logic out_valid_q, out_valid_d;
  rsp_t out_q;
  rsp_t rsp;
  eng_ctl_t ctl;
  eng_sts_t sts;

  lfuc_engine #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .req_i  (in_i),
    .cap_i  (cap_q),
    .sts_o  (sts),
    .rsp_o  (rsp)
  );

  assign in_stall_o  = sts.busy;
  assign cfg_ready_o = 1'b1;
  assign ctl.start   = in_valid_i && !sts.busy;
  assign ctl.ack     = sts.done && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl.ack) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ack) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("engine not busy after accepting a word");
  a_done_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.done |-> sts.busy)
    else $error("engine done while idle");
  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.evicted |-> !out_o.hit && out_o.read_value == '0)
    else $error("eviction reported on a hit or a get");
  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ack |=> out_valid_o && !sts.busy)
    else $error("result not loaded into output register");
`endif

endmodule
